// ===== src/pps_pkg.sv =====
// Shared constants, types and helpers of the preemptive priority scheduler.
package pps_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int ADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

  localparam int ID_W   = 16;
  localparam int ARR_W  = 31;
  localparam int DUR_W  = 31;
  localparam int PRIO_W = 8;
  localparam int TIME_W = 33;

  localparam logic [ARR_W-1:0]  ARRIVAL_MAX = 31'h7fffffff;
  localparam logic [TIME_W-1:0] TIME_MAX    = {TIME_W{1'b1}};

  localparam logic KIND_DONE   = 1'b0;
  localparam logic KIND_REJECT = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [ARR_W-1:0]  arr;
    logic [DUR_W-1:0]  rem;
  } entry_t;

  // request from the sequencer to the result stage
  typedef struct packed {
    logic              push;
    logic              flush;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] ftime;
    logic              kind;
  } emit_t;

  typedef struct packed {
    logic ok;
    logic held;
  } outq_stat_t;

  // a beats b: higher priority, or same priority and earlier arrival
  function automatic logic better(input entry_t a, input entry_t b);
    better = (a.prio > b.prio) || ((a.prio == b.prio) && (a.arr < b.arr));
  endfunction

endpackage

// ===== src/pps_if.sv =====
// Valid/ready channel interfaces for arrivals and results.
interface pps_in_if;
  logic                         valid;
  logic                         ready;
  logic [pps_pkg::ID_W-1:0]     job_id;
  logic [pps_pkg::ARR_W-1:0]    arrival_time;
  logic [pps_pkg::DUR_W-1:0]    duration;
  logic [pps_pkg::PRIO_W-1:0]   priority_req;
  logic                         drain;
  modport source (output valid, job_id, arrival_time, duration, priority_req, drain,
                  input ready);
  modport sink (input valid, job_id, arrival_time, duration, priority_req, drain,
                output ready);
endinterface

interface pps_out_if;
  logic                         valid;
  logic                         ready;
  logic [pps_pkg::ID_W-1:0]     done_id;
  logic [pps_pkg::TIME_W-1:0]   finish_time;
  logic                         result_kind;
  logic                         last;
  modport source (output valid, done_id, finish_time, result_kind, last, input ready);
  modport sink (input valid, done_id, finish_time, result_kind, last, output ready);
endinterface

// ===== src/pps_store.sv =====
// Pending-job memory: one write port, one registered read port.
module pps_store (
  input  logic                         clk,
  input  logic                         we,
  input  logic [pps_pkg::ADDR_W-1:0]   waddr,
  input  pps_pkg::entry_t              wdata,
  input  logic [pps_pkg::ADDR_W-1:0]   raddr,
  output pps_pkg::entry_t              rdata
);

  pps_pkg::entry_t mem [pps_pkg::QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/pps_outq.sv =====
// Result stage: holds the newest word until its last flag is known, then registers it out.
module pps_outq (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pps_pkg::emit_t         req,
  output pps_pkg::outq_stat_t    stat,
  pps_out_if.source              out_ch
);

  logic                          ov_r, ov_nxt;
  logic                          hv_r, hv_nxt;
  logic [pps_pkg::ID_W-1:0]      hid_r;
  logic [pps_pkg::TIME_W-1:0]    htime_r;
  logic                          hkind_r;
  logic [pps_pkg::ID_W-1:0]      oid_r;
  logic [pps_pkg::TIME_W-1:0]    otime_r;
  logic                          okind_r, olast_r;
  logic                          can, load_out, load_hold;

  assign can       = !ov_r || out_ch.ready;
  assign load_hold = req.push && can;
  assign load_out  = can && hv_r && (req.push || req.flush);

  always_comb begin
    ov_nxt = ov_r && !out_ch.ready;
    hv_nxt = hv_r;
    if (load_out) begin
      ov_nxt = 1'b1;
      hv_nxt = 1'b0;
    end
    if (load_hold) begin
      hv_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      hv_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      hv_r <= hv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      oid_r   <= hid_r;
      otime_r <= htime_r;
      okind_r <= hkind_r;
      olast_r <= !req.push;
    end
    if (load_hold) begin
      hid_r   <= req.id;
      htime_r <= req.ftime;
      hkind_r <= req.kind;
    end
  end

  assign stat.ok          = can;
  assign stat.held        = hv_r;
  assign out_ch.valid       = ov_r;
  assign out_ch.done_id     = oid_r;
  assign out_ch.finish_time = otime_r;
  assign out_ch.result_kind = okind_r;
  assign out_ch.last        = olast_r;

endmodule

// ===== src/preemptive_priority_scheduler_core.sv =====
// Top level: sequencer around a scan comparator shared by advance and drain, and the pending memory.
// Arrivals are taken one at a time; in_ch.ready is high only in the idle state. Each arrival
// runs pending jobs up to its arrival (scan, gap, compare, then apply: preempt, or finish and
// shift the later slots down), is inserted or rejected, drains all pending jobs if asked, and
// ends with a flush of the held word; output stalls lengthen any of these. A result word is
// held until the next word or the end of its arrival, then registered out. Reset (rst_n low,
// synchronous) clears time, count and handshake state; memory is not cleared.
module preemptive_priority_scheduler_core (
  input  logic        clk,
  input  logic        rst_n,
  pps_in_if.sink      in_ch,
  pps_out_if.source   out_ch
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_ADV_CHK = 4'd1;
  localparam logic [3:0] S_SCAN    = 4'd2;
  localparam logic [3:0] S_GAP     = 4'd3;
  localparam logic [3:0] S_CMP     = 4'd4;
  localparam logic [3:0] S_APPLY   = 4'd5;
  localparam logic [3:0] S_RM      = 4'd6;
  localparam logic [3:0] S_INS     = 4'd7;
  localparam logic [3:0] S_DRN_CHK = 4'd8;
  localparam logic [3:0] S_DRN     = 4'd9;
  localparam logic [3:0] S_FIN     = 4'd10;

  localparam int AW = pps_pkg::ADDR_W;
  localparam int CW = pps_pkg::CNT_W;
  localparam int TW = pps_pkg::TIME_W;

  logic [3:0]                  st_r, st_nxt;
  logic [TW-1:0]               cur_r, cur_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic [TW-1:0]               tgt_r, tgt_nxt;
  logic [pps_pkg::ID_W-1:0]    id_r, id_nxt;
  logic [pps_pkg::DUR_W-1:0]   dur_r, dur_nxt;
  logic [pps_pkg::PRIO_W-1:0]  prio_r, prio_nxt;
  logic                        drn_r, drn_nxt;
  logic                        mode_r, mode_nxt;
  logic [CW-1:0]               idx_r, idx_nxt;
  logic                        dv_r, dv_nxt;
  logic [CW-1:0]               didx_r, didx_nxt;
  pps_pkg::entry_t             best_r, best_nxt;
  logic [AW-1:0]               bidx_r, bidx_nxt;
  logic [TW-1:0]               gap_r, gap_nxt;
  logic                        fin_r, fin_nxt;
  logic [pps_pkg::DUR_W-1:0]   nrem_r, nrem_nxt;

  logic                        we;
  logic [AW-1:0]               waddr;
  pps_pkg::entry_t             wdata;
  pps_pkg::entry_t             rdata;
  logic                        issue;
  logic                        full;
  logic [TW-1:0]               arr33;
  logic [TW-1:0]               sum_adv;
  logic [TW:0]                 sum_drn;
  logic [TW-1:0]               nt_drn;
  logic [CW-1:0]               rm_start;
  pps_pkg::emit_t              req;
  pps_pkg::outq_stat_t         stat;

  pps_store u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx_r[AW-1:0]),
    .rdata (rdata)
  );

  pps_outq u_outq (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .stat   (stat),
    .out_ch (out_ch)
  );

  assign in_ch.ready = (st_r == S_IDLE);
  assign issue    = (idx_r < cnt_r);
  assign full     = (cnt_r == CW'(pps_pkg::QUEUE_DEPTH));
  assign arr33    = TW'(in_ch.arrival_time);
  assign sum_adv  = cur_r + TW'(best_r.rem);
  assign sum_drn  = {1'b0, cur_r} + (TW + 1)'(best_r.rem);
  assign nt_drn   = sum_drn[TW] ? pps_pkg::TIME_MAX : sum_drn[TW-1:0];
  assign rm_start = CW'(bidx_r) + CW'(1);

  always_comb begin
    st_nxt   = st_r;
    cur_nxt  = cur_r;
    cnt_nxt  = cnt_r;
    tgt_nxt  = tgt_r;
    id_nxt   = id_r;
    dur_nxt  = dur_r;
    prio_nxt = prio_r;
    drn_nxt  = drn_r;
    mode_nxt = mode_r;
    idx_nxt  = idx_r;
    dv_nxt   = 1'b0;
    didx_nxt = didx_r;
    best_nxt = best_r;
    bidx_nxt = bidx_r;
    gap_nxt  = gap_r;
    fin_nxt  = fin_r;
    nrem_nxt = nrem_r;
    we       = 1'b0;
    waddr    = bidx_r;
    wdata    = best_r;
    req      = '0;

    unique case (st_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          id_nxt   = in_ch.job_id;
          dur_nxt  = in_ch.duration;
          prio_nxt = in_ch.priority_req;
          drn_nxt  = in_ch.drain;
          tgt_nxt  = (arr33 < cur_r) ? cur_r : arr33;
          st_nxt   = S_ADV_CHK;
        end
      end
      S_ADV_CHK: begin
        if (cnt_r != '0 && cur_r < tgt_r) begin
          mode_nxt = 1'b0;
          idx_nxt  = '0;
          st_nxt   = S_SCAN;
        end else begin
          cur_nxt = tgt_r;
          st_nxt  = S_INS;
        end
      end
      S_SCAN: begin
        if (issue) begin
          idx_nxt  = idx_r + CW'(1);
          dv_nxt   = 1'b1;
          didx_nxt = idx_r;
        end
        if (dv_r) begin
          if (didx_r == '0 || pps_pkg::better(rdata, best_r)) begin
            best_nxt = rdata;
            bidx_nxt = didx_r[AW-1:0];
          end
          if (didx_r == cnt_r - CW'(1)) begin
            st_nxt = mode_r ? S_DRN : S_GAP;
          end
        end
      end
      S_GAP: begin
        gap_nxt = tgt_r - cur_r;
        st_nxt  = S_CMP;
      end
      S_CMP: begin
        fin_nxt  = (TW'(best_r.rem) <= gap_r);
        nrem_nxt = best_r.rem - gap_r[pps_pkg::DUR_W-1:0];
        st_nxt   = S_APPLY;
      end
      S_APPLY: begin
        if (fin_r) begin
          if (stat.ok) begin
            req.push  = 1'b1;
            req.id    = best_r.id;
            req.ftime = sum_adv;
            req.kind  = pps_pkg::KIND_DONE;
            cur_nxt   = sum_adv;
            idx_nxt   = rm_start;
            st_nxt    = S_RM;
          end
        end else begin
          // preempted at the arrival tick
          we        = 1'b1;
          wdata.rem = nrem_r;
          cur_nxt   = tgt_r;
          st_nxt    = S_INS;
        end
      end
      S_RM: begin
        if (issue) begin
          idx_nxt  = idx_r + CW'(1);
          dv_nxt   = 1'b1;
          didx_nxt = idx_r;
        end
        if (dv_r) begin
          we    = 1'b1;
          waddr = AW'(didx_r - CW'(1));
          wdata = rdata;
        end
        if (!issue && !dv_r) begin
          cnt_nxt = cnt_r - CW'(1);
          st_nxt  = mode_r ? S_DRN_CHK : S_ADV_CHK;
        end
      end
      S_INS: begin
        if (full) begin
          if (stat.ok) begin
            req.push  = 1'b1;
            req.id    = id_r;
            req.ftime = '0;
            req.kind  = pps_pkg::KIND_REJECT;
            st_nxt    = drn_r ? S_DRN_CHK : S_FIN;
          end
        end else begin
          we         = 1'b1;
          waddr      = AW'(cnt_r);
          wdata.id   = id_r;
          wdata.prio = prio_r;
          wdata.arr  = (tgt_r > TW'(pps_pkg::ARRIVAL_MAX)) ? pps_pkg::ARRIVAL_MAX
                                                            : tgt_r[pps_pkg::ARR_W-1:0];
          wdata.rem  = dur_r;
          cnt_nxt    = cnt_r + CW'(1);
          st_nxt     = drn_r ? S_DRN_CHK : S_FIN;
        end
      end
      S_DRN_CHK: begin
        if (cnt_r != '0) begin
          mode_nxt = 1'b1;
          idx_nxt  = '0;
          st_nxt   = S_SCAN;
        end else begin
          st_nxt = S_FIN;
        end
      end
      S_DRN: begin
        if (stat.ok) begin
          req.push  = 1'b1;
          req.id    = best_r.id;
          req.ftime = nt_drn;
          req.kind  = pps_pkg::KIND_DONE;
          cur_nxt   = nt_drn;
          idx_nxt   = rm_start;
          st_nxt    = S_RM;
        end
      end
      S_FIN: begin
        req.flush = 1'b1;
        if (!stat.held) begin
          st_nxt = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      cur_r <= '0;
      cnt_r <= '0;
      dv_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      cur_r <= cur_nxt;
      cnt_r <= cnt_nxt;
      dv_r  <= dv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tgt_r  <= tgt_nxt;
    id_r   <= id_nxt;
    dur_r  <= dur_nxt;
    prio_r <= prio_nxt;
    drn_r  <= drn_nxt;
    mode_r <= mode_nxt;
    idx_r  <= idx_nxt;
    didx_r <= didx_nxt;
    best_r <= best_nxt;
    bidx_r <= bidx_nxt;
    gap_r  <= gap_nxt;
    fin_r  <= fin_nxt;
    nrem_r <= nrem_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(pps_pkg::QUEUE_DEPTH))
    else $error("pending count above depth");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !stat.held)
    else $error("input ready while a result word is still held");

  a_time_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> cur_r >= $past(cur_r))
    else $error("current time went backward");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    req.push |-> stat.ok)
    else $error("result pushed with no room");

endmodule

// ===== test/tb_pps_ifaces.sv =====
// Testbench copies are not needed; interfaces come from src. Shared timing only.
`timescale 1ns / 100ps
package tb_pps_cfg;
  localparam int WATCHDOG_LIMIT = 200000;
endpackage

// ===== test/tb.sv =====
// Testbench for the preemptive priority scheduler: random arrivals checked against a predictor.
`timescale 1ns / 100ps
module tb;

  localparam int ID_W   = pps_pkg::ID_W;
  localparam int ARR_W  = pps_pkg::ARR_W;
  localparam int DUR_W  = pps_pkg::DUR_W;
  localparam int PRIO_W = pps_pkg::PRIO_W;
  localparam int TIME_W = pps_pkg::TIME_W;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] ftime;
    logic              kind;
    logic              last;
  } result_t;

  logic clk;
  logic rst_n;
  pps_in_if  in_ch();
  pps_out_if out_ch();

  preemptive_priority_scheduler_core uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  // scheduler state as predicted
  logic [TIME_W-1:0] now_t;
  int                n_pend;
  pps_pkg::entry_t   pend[pps_pkg::QUEUE_DEPTH];
  result_t           expected_q[$];
  logic [ARR_W-1:0]  next_arr;

  int  errors;
  bit  quiet;
  int  idle_cycles;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  task automatic report(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  function automatic void add_expected(input logic [ID_W-1:0] id,
      input logic [TIME_W-1:0] ftime, input logic kind);
    result_t r;
    r = '{id, ftime, kind, 1'b0};
    expected_q = {expected_q, r};
  endfunction

  function automatic int pick_best();
    int b;
    b = 0;
    for (int i = 1; i < n_pend; i++)
      if (pend[i].prio > pend[b].prio ||
          (pend[i].prio == pend[b].prio && pend[i].arr < pend[b].arr)) b = i;
    return b;
  endfunction

  function automatic void drop_entry(input int i);
    for (int j = i; j < n_pend - 1; j++) pend[j] = pend[j+1];
    n_pend--;
  endfunction

  function automatic void schedule_arrival(input logic [ID_W-1:0] id,
      input logic [ARR_W-1:0] arr, input logic [DUR_W-1:0] dur,
      input logic [PRIO_W-1:0] prio, input logic drn);
    logic [TIME_W-1:0] t, slice, rem;
    logic [TIME_W+1:0] nt;
    int b, k;
    k = 0;
    t = TIME_W'(arr);
    if (t < now_t) t = now_t;
    while (n_pend > 0 && now_t < t) begin
      b = pick_best();
      rem = TIME_W'(pend[b].rem);
      slice = t - now_t;
      if (rem < slice) slice = rem;
      rem -= slice;
      now_t += slice;
      if (rem == 0) begin
        add_expected(pend[b].id, now_t, pps_pkg::KIND_DONE);
        k++;
        drop_entry(b);
      end else pend[b].rem = rem[DUR_W-1:0];
    end
    now_t = t;
    if (n_pend >= pps_pkg::QUEUE_DEPTH) begin
      add_expected(id, '0, pps_pkg::KIND_REJECT);
      k++;
    end else begin
      pend[n_pend] = '{id, prio,
                       (t > TIME_W'(pps_pkg::ARRIVAL_MAX)) ? pps_pkg::ARRIVAL_MAX
                                                           : t[ARR_W-1:0],
                       dur};
      n_pend++;
    end
    if (drn) begin
      while (n_pend > 0) begin
        b = pick_best();
        nt = (TIME_W+2)'(now_t) + (TIME_W+2)'(pend[b].rem);
        now_t = (nt > (TIME_W+2)'(pps_pkg::TIME_MAX)) ? pps_pkg::TIME_MAX : nt[TIME_W-1:0];
        add_expected(pend[b].id, now_t, pps_pkg::KIND_DONE);
        k++;
        drop_entry(b);
      end
    end
    if (k > 0) expected_q[$].last = 1'b1;
  endfunction

  // valid stays high after an accept until the next word or an idle gap replaces it
  task automatic send_job(input logic [ID_W-1:0] id, input logic [ARR_W-1:0] arr,
      input logic [DUR_W-1:0] dur, input logic [PRIO_W-1:0] prio, input logic drn);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.job_id       <= id;
    in_ch.arrival_time <= arr;
    in_ch.duration     <= dur;
    in_ch.priority_req <= prio;
    in_ch.drain        <= drn;
    do @(posedge clk); while (!in_ch.ready);
    schedule_arrival(id, arr, dur, prio, drn);
  endtask

  task automatic wait_empty();
    in_ch.valid <= 1'b0;
    while (expected_q.size() > 0) @(posedge clk);
  endtask

  // result checker and sink stalls
  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) report("unexpected word");
      else begin
        e = expected_q[0];
        expected_q.delete(0);
        if (out_ch.done_id !== e.id)
          report($sformatf("done_id %0d exp %0d", out_ch.done_id, e.id));
        if (out_ch.finish_time !== e.ftime)
          report($sformatf("finish_time %0d exp %0d id %0d",
                           out_ch.finish_time, e.ftime, e.id));
        if (out_ch.result_kind !== e.kind)
          report($sformatf("result_kind %0b exp %0b id %0d", out_ch.result_kind, e.kind, e.id));
        if (out_ch.last !== e.last)
          report($sformatf("last %0b exp %0b id %0d", out_ch.last, e.last, e.id));
      end
    end
  end

  int stall_left;
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_ch.ready <= 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= (stall_left == 0);
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 4);
      out_ch.ready <= 1'b0;
    end else out_ch.ready <= 1'b1;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= tb_pps_cfg::WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [ARR_W-1:0] step_time(input int max_step);
    logic [ARR_W:0] t;
    t = {1'b0, next_arr} + (ARR_W+1)'($urandom_range(0, max_step));
    if (t > {1'b0, pps_pkg::ARRIVAL_MAX}) t = {1'b0, pps_pkg::ARRIVAL_MAX};
    return t[ARR_W-1:0];
  endfunction

  task automatic test_directed();
    send_job(16'h0000, 31'd0, 31'd0, 8'h00, 1'b0);
    send_job(16'hffff, 31'd0, 31'd5, 8'hff, 1'b0);
    send_job(16'h1234, 31'd2, 31'd10, 8'h10, 1'b0);   // waits behind later higher prio
    send_job(16'h0001, 31'd4, 31'd3, 8'h80, 1'b0);
    send_job(16'h0002, 31'd1, 31'd0, 8'h80, 1'b0);    // early arrival clamps
    send_job(16'h0003, 31'd100, 31'd7, 8'h01, 1'b0);  // idle gap
    send_job(16'h0004, 31'd100, 31'd7, 8'h01, 1'b0);  // same tick
    send_job(16'h0005, 31'd200, 31'd0, 8'h05, 1'b1);
    for (int i = 0; i < 33; i++)                        // fill + reject
      send_job(ID_W'(16'h0100 + i), 31'd300, 31'd1, i[7:0], 1'b0);
    send_job(16'h0200, 31'd300, 31'd2, 8'h7f, 1'b1);  // rejected but drains
    wait_empty();
    next_arr = 31'd300;
  endtask

  task automatic test_saturation();
    send_job(16'haaaa, pps_pkg::ARRIVAL_MAX, pps_pkg::ARRIVAL_MAX, 8'h55, 1'b0);
    send_job(16'h5555, pps_pkg::ARRIVAL_MAX, pps_pkg::ARRIVAL_MAX, 8'haa, 1'b0);
    send_job(16'h7777, pps_pkg::ARRIVAL_MAX, pps_pkg::ARRIVAL_MAX, 8'haa, 1'b0);
    send_job(16'h8888, pps_pkg::ARRIVAL_MAX, pps_pkg::ARRIVAL_MAX, 8'h00, 1'b1);
    send_job(16'h9999, 31'd0, pps_pkg::ARRIVAL_MAX, 8'h01, 1'b1);
    send_job(16'h9998, 31'd0, pps_pkg::ARRIVAL_MAX, 8'h01, 1'b1);
    send_job(16'h9997, 31'd0, pps_pkg::ARRIVAL_MAX, 8'h01, 1'b1);
    send_job(16'h9996, 31'd0, pps_pkg::ARRIVAL_MAX, 8'h01, 1'b1); // time already saturated
    send_job(16'h9995, 31'd0, 31'd3, 8'h01, 1'b1);                 // stays saturated
    wait_empty();
  endtask

  task automatic test_random(input int count, input bit tail);
    logic [DUR_W-1:0] d;
    quiet = 0;
    for (int i = 0; i < count; i++) begin
      if (tail && i == count - 60) quiet = 1;
      if (i == count / 2) wait_empty();   // pause until all results are out
      next_arr = step_time(($urandom_range(0, 3) == 0) ? 200 : 8);
      d = ($urandom_range(0, 9) == 0) ? DUR_W'($urandom) : DUR_W'($urandom_range(0, 20));
      send_job(ID_W'($urandom), next_arr, d, PRIO_W'($urandom),
               ($urandom_range(0, 11) == 0));
    end
    send_job(ID_W'($urandom), next_arr, '0, PRIO_W'($urandom), 1'b1);
  endtask

  initial begin
    errors = 0; quiet = 0; n_pend = 0; now_t = '0; next_arr = '0;
    rst_n = 0;
    in_ch.valid = 0; in_ch.job_id = '0; in_ch.arrival_time = '0;
    in_ch.duration = '0; in_ch.priority_req = '0; in_ch.drain = 0;
    out_ch.ready = 1'b1;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_random(160, 1'b0);
    test_saturation();
    next_arr = '0; // later arrivals clamp to saturated time
    test_random(200, 1'b1);
    wait_empty();
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

// ===== preemptive_priority_scheduler_core.f =====
src/pps_pkg.sv
src/pps_if.sv
src/pps_store.sv
src/pps_outq.sv
src/preemptive_priority_scheduler_core.sv
test/tb_pps_ifaces.sv
test/tb.sv
